>>> design/assert_macros.svh
// Assertion macros shared by the console writer modules.
// No dependencies; taken in by `include before the module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tcw_pkg.sv
// Types, constants and codes of the text console writer.
// No dependencies; used by the interfaces and all modules.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int POS_W      = 8;
	localparam int OP_W       = 3;
	localparam int NIB_W      = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int TAB_STEP   = 8;

	localparam logic [CHAR_W-1:0] BLANK      = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST = 8'd15;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 8'd1;

	typedef enum logic [OP_W-1:0] {
		OP_PUT     = 3'd0,
		OP_PUT_AT  = 3'd1,
		OP_SET_CUR = 3'd2,
		OP_CLS     = 3'd3,
		OP_CLR_ROW = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_HOME,
		CUR_CR,
		CUR_TAB,
		CUR_DOWN,
		CUR_SET,
		CUR_INC
	} cur_op_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_WR_CHAR,
		MEM_WR_AT,
		MEM_RD_AT,
		MEM_FILL,
		MEM_COPY_RD,
		MEM_COPY_WR
	} mem_op_t;

	typedef enum logic [2:0] {
		SW_HOLD,
		SW_ALL,
		SW_ROW,
		SW_COPY,
		SW_LAST
	} sw_op_t;

	typedef struct packed {
		logic    cap;
		cur_op_t cur;
		mem_op_t mem;
		sw_op_t  sw;
		logic    sw_step;
		logic    fill_rst;
		logic    res_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            enabled;
		logic            is_lf;
		logic            is_cr;
		logic            is_tab;
		logic            tab_wrap;
		logic            col_full;
		logic            row_last;
		logic            pos_ok;
		logic            row_ok;
		logic            sw_last;
	} tcw_stat_t;

endpackage

>>> design/tcw_item_if.sv
// Request channel carrying one console operation.
// Depends on tcw_pkg for field widths.
interface tcw_item_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] char_code;
	logic [POS_W-1:0]  col;
	logic [POS_W-1:0]  row;
	logic [NIB_W-1:0]  fg;
	logic [NIB_W-1:0]  bg;

	modport source (output valid, op, char_code, col, row, fg, bg, input ready);
	modport sink   (input valid, op, char_code, col, row, fg, bg, output ready);
endinterface

>>> design/tcw_res_if.sv
// Result channel: read cell data and cursor position.
// Depends on tcw_pkg for field widths.
interface tcw_res_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;
	logic [COL_W-1:0]  col_now;
	logic [ROW_W-1:0]  row_now;

	modport source (output valid, read_char, read_attr, col_now, row_now, input ready);
	modport sink   (input valid, read_char, read_attr, col_now, row_now, output ready);
endinterface

>>> design/tcw_cfg_if.sv
// Register write channel: index and write data.
// Depends on tcw_pkg for field widths.
interface tcw_cfg_if;
	import tcw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> design/text_console_writer_top.sv
// Text console writer top level: controller, datapath and the channel ports.
// Depends on tcw_pkg, tcw_item_if, tcw_res_if, tcw_cfg_if, tcw_ctrl, tcw_datapath.
// One request at a time: an accepted request is captured, run in EXEC and its result loaded
// in DONE once the result register is free; a put char that first wraps adds a WRITE state.
// A scroll copies each cell one row up via COPY_RD and COPY_WR, as the store never reads and
// writes at once, then fills the last row; clear screen fills CELLS cells, a row COLUMNS.
// Reset: cursor home, registers to defaults, then a fill of the store with blanks
// in attribute 0x0F during which no request is taken; register writes are taken throughout.
module text_console_writer_top (
	input logic     clk,
	input logic     arst_n,
	tcw_item_if.sink  item,
	tcw_res_if.source res,
	tcw_cfg_if.sink   cfg
);
	import tcw_pkg::*;

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	assign cfg.ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.cmd       (cmd),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (res.valid),
		.out_ready (res.ready)
	);

	tcw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item_op   (item.op),
		.item_char (item.char_code),
		.item_col  (item.col),
		.item_row  (item.row),
		.item_fg   (item.fg),
		.item_bg   (item.bg),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.read_char (res.read_char),
		.read_attr (res.read_attr),
		.col_now   (res.col_now),
		.row_now   (res.row_now)
	);

endmodule

>>> design/tcw_datapath.sv
// Datapath: screen store, cursor, sweep counter, registers and result register.
// Depends on tcw_pkg and assert_macros.svh; driven by tcw_ctrl commands.
`include "assert_macros.svh"

module tcw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::tcw_cmd_t              cmd,
	output tcw_pkg::tcw_stat_t             stat,
	input  logic [tcw_pkg::OP_W-1:0]       item_op,
	input  logic [tcw_pkg::CHAR_W-1:0]     item_char,
	input  logic [tcw_pkg::POS_W-1:0]      item_col,
	input  logic [tcw_pkg::POS_W-1:0]      item_row,
	input  logic [tcw_pkg::NIB_W-1:0]      item_fg,
	input  logic [tcw_pkg::NIB_W-1:0]      item_bg,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [tcw_pkg::CHAR_W-1:0]     read_char,
	output logic [tcw_pkg::ATTR_W-1:0]     read_attr,
	output logic [tcw_pkg::COL_W-1:0]      col_now,
	output logic [tcw_pkg::ROW_W-1:0]      row_now
);
	import tcw_pkg::*;

	logic [CHAR_W+ATTR_W-1:0] mem [CELLS];

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  icol_q;
	logic [POS_W-1:0]  irow_q;
	logic [NIB_W-1:0]  fg_q;
	logic [NIB_W-1:0]  bg_q;

	logic [ATTR_W-1:0] text_attr_q;
	logic              enabled_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] sw_idx_q;
	logic [ADDR_W-1:0] sw_end_q;
	logic [CHAR_W+ATTR_W-1:0] rdata_q;

	logic [CHAR_W-1:0] res_char_q;
	logic [ATTR_W-1:0] res_attr_q;
	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;

	logic [COL_W:0]    tab_sum;
	logic [COL_W:0]    tab_col;
	logic              pos_ok;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] row_base;
	logic [ATTR_W-1:0] fill_attr;

	logic                     we;
	logic                     re;
	logic [ADDR_W-1:0]        waddr;
	logic [ADDR_W-1:0]        raddr;
	logic [CHAR_W+ATTR_W-1:0] wdata;

	assign tab_sum   = {1'b0, col_q} + (COL_W+1)'(TAB_STEP);
	assign tab_col   = {tab_sum[COL_W:3], 3'b000};
	assign pos_ok    = (irow_q < POS_W'(ROWS)) && (icol_q < POS_W'(COLUMNS));
	assign cur_addr  = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
	assign row_base  = ADDR_W'(ADDR_W'(irow_q[ROW_W-1:0]) * ADDR_W'(COLUMNS));
	assign item_addr = row_base + ADDR_W'(icol_q[COL_W-1:0]);
	assign fill_attr = cmd.fill_rst ? RESET_ATTR : text_attr_q;

	always_comb begin
		stat.op       = op_q;
		stat.enabled  = enabled_q;
		stat.is_lf    = (ch_q == CH_LF);
		stat.is_cr    = (ch_q == CH_CR);
		stat.is_tab   = (ch_q == CH_TAB);
		stat.tab_wrap = (tab_col >= (COL_W+1)'(COLUMNS));
		stat.col_full = (col_q >= COL_W'(COLUMNS));
		stat.row_last = (row_q == ROW_W'(ROWS - 1));
		stat.pos_ok   = pos_ok;
		stat.row_ok   = (irow_q < POS_W'(ROWS));
		stat.sw_last  = (sw_idx_q == sw_end_q);
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = sw_idx_q;
		raddr = item_addr;
		wdata = {fill_attr, BLANK};
		unique case (cmd.mem)
			MEM_NONE: begin
			end
			MEM_WR_CHAR: begin
				we    = 1'b1;
				waddr = cur_addr;
				wdata = {text_attr_q, ch_q};
			end
			MEM_WR_AT: begin
				we    = 1'b1;
				waddr = item_addr;
				wdata = {bg_q, fg_q, ch_q};
			end
			MEM_RD_AT: begin
				re = 1'b1;
			end
			MEM_FILL: begin
				we = 1'b1;
			end
			MEM_COPY_RD: begin
				re    = 1'b1;
				raddr = sw_idx_q + ADDR_W'(COLUMNS);
			end
			MEM_COPY_WR: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= item_op;
			ch_q   <= item_char;
			icol_q <= item_col;
			irow_q <= item_row;
			fg_q   <= item_fg;
			bg_q   <= item_bg;
		end
		if (cmd.res_load) begin
			if ((op_q == OP_READ) && pos_ok) begin
				res_char_q <= rdata_q[CHAR_W-1:0];
				res_attr_q <= rdata_q[CHAR_W+ATTR_W-1:CHAR_W];
			end else begin
				res_char_q <= '0;
				res_attr_q <= '0;
			end
			res_col_q <= col_q;
			res_row_q <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= TEXT_ATTR_RST;
			enabled_q   <= 1'b1;
		end else if (cfg_we) begin
			priority if (cfg_index == REG_TEXT_ATTR) begin
				text_attr_q <= cfg_data[ATTR_W-1:0];
			end else if (cfg_index == REG_ENABLED) begin
				enabled_q <= cfg_data[0];
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			unique case (cmd.cur)
				CUR_HOLD: begin
				end
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				CUR_CR: begin
					col_q <= '0;
				end
				CUR_TAB: begin
					col_q <= tab_col[COL_W-1:0];
				end
				CUR_DOWN: begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end
				CUR_SET: begin
					col_q <= (icol_q >= POS_W'(COLUMNS)) ? COL_W'(COLUMNS - 1)
						: icol_q[COL_W-1:0];
					row_q <= (irow_q >= POS_W'(ROWS)) ? ROW_W'(ROWS - 1)
						: irow_q[ROW_W-1:0];
				end
				CUR_INC: begin
					col_q <= col_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_idx_q <= '0;
			sw_end_q <= ADDR_W'(CELLS - 1);
		end else begin
			unique case (cmd.sw)
				SW_HOLD: begin
					if (cmd.sw_step) begin
						sw_idx_q <= sw_idx_q + 1'b1;
					end
				end
				SW_ALL: begin
					sw_idx_q <= '0;
					sw_end_q <= ADDR_W'(CELLS - 1);
				end
				SW_ROW: begin
					sw_idx_q <= row_base;
					sw_end_q <= row_base + ADDR_W'(COLUMNS - 1);
				end
				SW_COPY: begin
					sw_idx_q <= '0;
					sw_end_q <= ADDR_W'(CELLS - COLUMNS - 1);
				end
				SW_LAST: begin
					sw_idx_q <= ADDR_W'(CELLS - COLUMNS);
					sw_end_q <= ADDR_W'(CELLS - 1);
				end
				default: begin
				end
			endcase
		end
	end

	assign read_char = res_char_q;
	assign read_attr = res_attr_q;
	assign col_now   = res_col_q;
	assign row_now   = res_row_q;

	`TCW_ASSERT_IMP(a_cursor_range, clk, arst_n, 1'b1, (col_q <= COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)), "cursor out of range")
	`TCW_ASSERT_IMP(a_waddr_range, clk, arst_n, we, {1'b0, waddr} < (ADDR_W+1)'(CELLS), "store write beyond last cell")
	`TCW_ASSERT_IMP(a_one_port_op, clk, arst_n, re, !we, "store read and write in one cycle")

endmodule

>>> design/tcw_ctrl.sv
// Controller: sequences each request, the reset fill, scrolls and clears.
// Depends on tcw_pkg and assert_macros.svh; drives tcw_datapath.
`include "assert_macros.svh"

module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t  cmd,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   pend_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		logic do_lf;
		logic lf_pend;

		do_lf        = 1'b0;
		lf_pend      = 1'b0;
		state_d      = state_q;
		pend_d       = pend_q;
		cmd          = '0;
		cmd.cur      = CUR_HOLD;
		cmd.mem      = MEM_NONE;
		cmd.sw       = SW_HOLD;
		in_ready     = 1'b0;

		unique case (state_q)
			ST_INIT: begin
				cmd.mem      = MEM_FILL;
				cmd.fill_rst = 1'b1;
				cmd.sw_step  = 1'b1;
				if (stat.sw_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (stat.op)
					OP_PUT: begin
						if (stat.enabled) begin
							priority if (stat.is_lf) begin
								do_lf = 1'b1;
							end else if (stat.is_cr) begin
								cmd.cur = CUR_CR;
							end else if (stat.is_tab) begin
								if (stat.tab_wrap) begin
									do_lf = 1'b1;
								end else begin
									cmd.cur = CUR_TAB;
								end
							end else if (stat.col_full) begin
								do_lf   = 1'b1;
								lf_pend = 1'b1;
							end else begin
								cmd.mem = MEM_WR_CHAR;
								cmd.cur = CUR_INC;
							end
						end
					end
					OP_PUT_AT: begin
						if (stat.pos_ok) begin
							cmd.mem = MEM_WR_AT;
						end
					end
					OP_SET_CUR: begin
						cmd.cur = CUR_SET;
					end
					OP_CLS: begin
						if (stat.enabled) begin
							cmd.sw  = SW_ALL;
							cmd.cur = CUR_HOME;
							pend_d  = 1'b0;
							state_d = ST_FILL;
						end
					end
					OP_CLR_ROW: begin
						if (stat.enabled && stat.row_ok) begin
							cmd.sw  = SW_ROW;
							pend_d  = 1'b0;
							state_d = ST_FILL;
						end
					end
					OP_READ: begin
						if (stat.pos_ok) begin
							cmd.mem = MEM_RD_AT;
						end
					end
					default: begin
					end
				endcase
				if (do_lf) begin
					if (!stat.row_last) begin
						cmd.cur = CUR_DOWN;
						state_d = lf_pend ? ST_WRITE : ST_DONE;
					end else begin
						cmd.cur = CUR_CR;
						cmd.sw  = SW_COPY;
						pend_d  = lf_pend;
						state_d = ST_COPY_RD;
					end
				end
			end
			ST_WRITE: begin
				cmd.mem = MEM_WR_CHAR;
				cmd.cur = CUR_INC;
				state_d = ST_DONE;
			end
			ST_COPY_RD: begin
				cmd.mem = MEM_COPY_RD;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				cmd.mem = MEM_COPY_WR;
				if (stat.sw_last) begin
					cmd.sw  = SW_LAST;
					state_d = ST_FILL;
				end else begin
					cmd.sw_step = 1'b1;
					state_d     = ST_COPY_RD;
				end
			end
			ST_FILL: begin
				cmd.mem = MEM_FILL;
				if (stat.sw_last) begin
					state_d = pend_q ? ST_WRITE : ST_DONE;
				end else begin
					cmd.sw_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`TCW_ASSERT_NXT(a_accept_exec, clk, arst_n, cmd.cap, state_q == ST_EXEC, "accepted request not executed")
	`TCW_ASSERT_NXT(a_result_shown, clk, arst_n, cmd.res_load, out_valid_q && (state_q == ST_IDLE), "result not presented")
	`TCW_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.res_load && out_valid_q, out_ready, "result overwritten before taken")

endmodule
